>>> hw/rtl/cplp_pkg.sv
// Types and constants shared by the charge power limit policy block.
`timescale 1ns / 1ps

package cplp_pkg;

    typedef struct packed {
        logic [6:0]        state_of_charge;
        logic              mppt_shut_down;
        logic              dcac_charge_shut_down;
        logic              system_charge_permit;
        logic              force_close;
        logic [15:0]       bms_power_limit;
        logic              mppt_charge_permit;
        logic              mppt_running;
        logic              dcac_charge_permit;
        logic              dcac_running;
        logic signed [7:0] max_temperature;
    } item_t;

    typedef struct packed {
        logic [15:0] mppt_power_setpoint;
        logic [15:0] dcac_power_setpoint;
    } result_t;

    localparam int BASE_W = 13;

    typedef struct packed {
        logic [BASE_W-1:0] mppt_base;
        logic [15:0]       dcac_input_rating;
        logic [6:0]        soc_full_level;
        logic [6:0]        soc_recharge_level;
        logic signed [7:0] temp_gear1_exit;
        logic signed [7:0] temp_gear_mid;
        logic signed [7:0] temp_gear2_enter;
    } cfg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MPPT_INPUT_RATING  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DCAC_INPUT_RATING  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOC_FULL_LEVEL     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SOC_RECHARGE_LEVEL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_GEAR1_EXIT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_GEAR_MID      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_GEAR2_ENTER   = 3'd6;

    // Multiplying by this and shifting right by DIV10_SHIFT divides any 16-bit value by ten.
    localparam logic [31:0] DIV10_RECIP = 32'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [6:0]        SOC_FULL_RESET     = 7'd100;
    localparam logic [6:0]        SOC_RECHARGE_RESET = 7'd90;
    localparam logic signed [7:0] GEAR1_EXIT_RESET   = 8'sd60;
    localparam logic signed [7:0] GEAR_MID_RESET     = 8'sd65;
    localparam logic signed [7:0] GEAR2_ENTER_RESET  = 8'sd70;

endpackage

>>> hw/rtl/cplp_cfg_regs.sv
// Configuration register file; the MPPT rating is stored as its tenth.
`timescale 1ns / 1ps

module cplp_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cplp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cplp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output cplp_pkg::cfg_t                      cfg
);

    cplp_pkg::cfg_t cfg_reg;
    logic [31:0]    base_prod;

    assign base_prod = 32'(cfg_wdata) * cplp_pkg::DIV10_RECIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mppt_base          <= '0;
            cfg_reg.dcac_input_rating  <= '0;
            cfg_reg.soc_full_level     <= cplp_pkg::SOC_FULL_RESET;
            cfg_reg.soc_recharge_level <= cplp_pkg::SOC_RECHARGE_RESET;
            cfg_reg.temp_gear1_exit    <= cplp_pkg::GEAR1_EXIT_RESET;
            cfg_reg.temp_gear_mid      <= cplp_pkg::GEAR_MID_RESET;
            cfg_reg.temp_gear2_enter   <= cplp_pkg::GEAR2_ENTER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cplp_pkg::REG_MPPT_INPUT_RATING:
                    cfg_reg.mppt_base <= base_prod[cplp_pkg::DIV10_SHIFT +: cplp_pkg::BASE_W];
                cplp_pkg::REG_DCAC_INPUT_RATING:
                    cfg_reg.dcac_input_rating <= cfg_wdata;
                cplp_pkg::REG_SOC_FULL_LEVEL:
                    cfg_reg.soc_full_level <= cfg_wdata[6:0];
                cplp_pkg::REG_SOC_RECHARGE_LEVEL:
                    cfg_reg.soc_recharge_level <= cfg_wdata[6:0];
                cplp_pkg::REG_TEMP_GEAR1_EXIT:
                    cfg_reg.temp_gear1_exit <= signed'(cfg_wdata[7:0]);
                cplp_pkg::REG_TEMP_GEAR_MID:
                    cfg_reg.temp_gear_mid <= signed'(cfg_wdata[7:0]);
                cplp_pkg::REG_TEMP_GEAR2_ENTER:
                    cfg_reg.temp_gear2_enter <= signed'(cfg_wdata[7:0]);
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/cplp_policy.sv
// Full latch, temperature gear state and the setpoint logic for one beat.
`timescale 1ns / 1ps

module cplp_policy (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  cplp_pkg::item_t     item,
    input  cplp_pkg::cfg_t      cfg,
    output cplp_pkg::result_t   result
);

    typedef enum logic [1:0] {
        GEAR_FULL  = 2'd0,
        GEAR_THREE = 2'd1,
        GEAR_HALF  = 2'd2,
        GEAR_SPARE = 2'd3
    } gear_t;

    gear_t                       gear_reg;
    gear_t                       gear_next;
    logic                        full_reg;
    logic                        full_next;
    logic                        charge_ok;
    logic                        mppt_on;
    logic                        dcac_on;
    logic [cplp_pkg::BASE_W+1:0] base_x3;
    logic [cplp_pkg::BASE_W-1:0] derated;
    logic [15:0]                 derated_ext;
    logic [15:0]                 mppt_sp;
    logic [15:0]                 dcac_sp;

    always_comb
    begin
        full_next = full_reg;
        if (item.state_of_charge == cfg.soc_full_level)
        begin
            full_next = 1'b1;
        end
        else if (item.state_of_charge <= cfg.soc_recharge_level)
        begin
            full_next = 1'b0;
        end
        if (item.mppt_shut_down && item.dcac_charge_shut_down)
        begin
            full_next = 1'b0;
        end
    end

    assign charge_ok = item.system_charge_permit && !item.force_close && !full_next
                       && (item.bms_power_limit != 16'd0);
    assign mppt_on   = charge_ok && item.mppt_charge_permit && item.mppt_running;
    assign dcac_on   = charge_ok && item.dcac_charge_permit && item.dcac_running;

    assign base_x3 = {2'b00, cfg.mppt_base} + {1'b0, cfg.mppt_base, 1'b0};

    always_comb
    begin
        gear_next = gear_reg;
        derated   = cfg.mppt_base;
        case (gear_reg)
            GEAR_THREE:
            begin
                derated = base_x3[cplp_pkg::BASE_W+1:2];
                if (item.max_temperature <= cfg.temp_gear1_exit)
                begin
                    gear_next = GEAR_FULL;
                end
                else if (item.max_temperature > cfg.temp_gear2_enter)
                begin
                    gear_next = GEAR_HALF;
                end
            end
            GEAR_HALF:
            begin
                derated = {1'b0, cfg.mppt_base[cplp_pkg::BASE_W-1:1]};
                if (item.max_temperature <= cfg.temp_gear_mid)
                begin
                    gear_next = GEAR_THREE;
                end
            end
            default:
            begin
                if (item.max_temperature > cfg.temp_gear2_enter)
                begin
                    gear_next = GEAR_HALF;
                end
                else if (item.max_temperature > cfg.temp_gear_mid)
                begin
                    gear_next = GEAR_THREE;
                end
            end
        endcase
    end

    assign derated_ext = 16'(derated);

    always_comb
    begin
        mppt_sp = '0;
        dcac_sp = '0;
        if (mppt_on)
        begin
            mppt_sp = (item.bms_power_limit < derated_ext) ? item.bms_power_limit
                                                           : derated_ext;
        end
        if (dcac_on)
        begin
            dcac_sp = (item.bms_power_limit < cfg.dcac_input_rating) ? item.bms_power_limit
                                                                     : cfg.dcac_input_rating;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            gear_reg <= GEAR_FULL;
        end
        else if (advance)
        begin
            full_reg <= full_next;
            if (mppt_on)
            begin
                gear_reg <= gear_next;
            end
        end
    end

    assign result.mppt_power_setpoint = mppt_sp;
    assign result.dcac_power_setpoint = dcac_sp;

endmodule

>>> hw/rtl/charge_power_limit_policy.sv
// Charge power limit policy: input register, policy logic and result register.
//
// Each beat on the item channel is one management tick. The block answers each
// tick with exactly one beat on the result channel carrying the MPPT and DCAC
// power setpoints. An accepted item lands in the input register, passes through
// the policy logic and is captured in the result register once that register is
// free or its beat is taken. While item_stall stays low, a new item can be
// accepted every cycle, giving a throughput of one item per cycle.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata,
// taking effect at the next clock edge; writes to unused indexes are ignored.
// Reset clears both pipeline stages, the full latch and the temperature gear,
// and loads the default levels and thresholds. When the receiver holds
// result_stall, the result stays in place, the input register fills, and
// item_stall rises once both stages hold beats.
`timescale 1ns / 1ps

module charge_power_limit_policy (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  cplp_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output cplp_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [cplp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cplp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    cplp_pkg::cfg_t    cfg;
    cplp_pkg::item_t   item_reg;
    logic              item_valid_reg;
    cplp_pkg::result_t result_next;
    cplp_pkg::result_t result_reg;
    logic              result_valid_reg;
    logic              result_load;
    logic              advance;
    logic              item_take;

    assign result_load = !result_valid_reg || !result_stall;
    assign advance     = item_valid_reg && result_load;
    assign item_stall  = item_valid_reg && !result_load;
    assign item_take   = item_valid && !item_stall;

    cplp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cplp_policy u_policy (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (result_load)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> bench/tb_charge_power_limit_policy.sv
// Self-checking testbench for the charge power limit policy block with random idling and stalls.
`timescale 1ns / 1ps

module tb_charge_power_limit_policy;

    typedef enum logic [1:0] {
        GEAR_FULL          = 2'd0,
        GEAR_THREE_QUARTER = 2'd1,
        GEAR_HALF          = 2'd2
    } gear_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } idle_t;

    localparam logic [cplp_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 60;
    localparam int RANDOM_TICKS = 172;
    localparam int MAX_REPORTS  = 10;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   item_valid = 1'b0;
    logic                                   item_stall;
    cplp_pkg::item_t                        item = '0;
    logic                                   result_valid;
    logic                                   result_stall = 1'b0;
    cplp_pkg::result_t                      result;
    logic                                   cfg_we = 1'b0;
    logic [cplp_pkg::CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [cplp_pkg::CFG_DATA_W-1:0]        cfg_wdata = '0;

    // Predictor copy of the configuration and of the block state.
    logic [15:0]       mppt_rating = 16'd0;
    logic [15:0]       dcac_rating = 16'd0;
    logic [6:0]        full_level = cplp_pkg::SOC_FULL_RESET;
    logic [6:0]        recharge_level = cplp_pkg::SOC_RECHARGE_RESET;
    int                gear1_exit = 60;
    int                gear_mid = 65;
    int                gear2_enter = 70;
    logic              pack_full = 1'b0;
    gear_t             derate_gear = GEAR_FULL;

    cplp_pkg::item_t   ticks_to_send[$];
    cplp_pkg::result_t setpoints_due[$];
    int                error_count = 0;
    int                cycle_count = 0;
    logic              tick_taken = 1'b0;
    int                send_gap = 0;
    int                stall_left = 0;
    int                hold_left = 0;
    int                holds_asked = 0;
    int                holds_served = 0;
    idle_t             send_mode = IDLE_NONE;
    idle_t             recv_mode = IDLE_NONE;
    cplp_pkg::item_t   next_tick;
    logic              next_valid;
    int                stall_len;

    charge_power_limit_policy i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic cplp_pkg::result_t predict_setpoints(cplp_pkg::item_t tick);
        cplp_pkg::result_t sp;
        int                temp_c;
        int unsigned       base;
        int unsigned       derated;
        sp = '0;
        temp_c = int'($signed(tick.max_temperature));
        if (tick.state_of_charge == full_level)
            pack_full = 1'b1;
        else if (tick.state_of_charge <= recharge_level)
            pack_full = 1'b0;
        if (tick.mppt_shut_down && tick.dcac_charge_shut_down)
            pack_full = 1'b0;
        if (tick.system_charge_permit && !tick.force_close && !pack_full
            && tick.bms_power_limit != 16'd0)
        begin
            if (tick.mppt_charge_permit && tick.mppt_running)
            begin
                base = mppt_rating / 10;
                case (derate_gear)
                    GEAR_THREE_QUARTER:
                    begin
                        if (temp_c <= gear1_exit)
                            derate_gear = GEAR_FULL;
                        else if (temp_c > gear2_enter)
                            derate_gear = GEAR_HALF;
                        derated = (base * 3) / 4;
                    end
                    GEAR_HALF:
                    begin
                        if (temp_c <= gear_mid)
                            derate_gear = GEAR_THREE_QUARTER;
                        derated = base / 2;
                    end
                    default:
                    begin
                        if (temp_c > gear2_enter)
                            derate_gear = GEAR_HALF;
                        else if (temp_c > gear_mid)
                            derate_gear = GEAR_THREE_QUARTER;
                        derated = base;
                    end
                endcase
                if (derated > base)
                    derated = base;
                if (tick.bms_power_limit < derated)
                    sp.mppt_power_setpoint = tick.bms_power_limit;
                else
                    sp.mppt_power_setpoint = derated[15:0];
            end
            if (tick.dcac_charge_permit && tick.dcac_running)
                sp.dcac_power_setpoint = (tick.bms_power_limit < dcac_rating)
                    ? tick.bms_power_limit : dcac_rating;
        end
        return sp;
    endfunction

    function automatic int pick_gap(idle_t mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode == IDLE_NONE)
            return 0;
        if (mode == IDLE_LIGHT)
        begin
            if (roll < 70)
                return 0;
            if (roll < 95)
                return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    function automatic cplp_pkg::item_t charge_tick(int soc, int bms, int temp);
        cplp_pkg::item_t tick;
        tick = '0;
        tick.state_of_charge      = soc[6:0];
        tick.system_charge_permit = 1'b1;
        tick.bms_power_limit      = bms[15:0];
        tick.mppt_charge_permit   = 1'b1;
        tick.mppt_running         = 1'b1;
        tick.dcac_charge_permit   = 1'b1;
        tick.dcac_running         = 1'b1;
        tick.max_temperature      = temp[7:0];
        return tick;
    endfunction

    function automatic cplp_pkg::item_t random_tick();
        cplp_pkg::item_t tick;
        int              soc_v;
        int              temp_v;
        int              bms_v;
        int              roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            soc_v = $urandom_range(0, 127);
        else if (roll < 45)
            soc_v = int'(full_level) + int'($urandom_range(0, 4)) - 2;
        else if (roll < 75)
            soc_v = int'(recharge_level) + int'($urandom_range(0, 6)) - 3;
        else
            soc_v = $urandom_range(0, 100);
        if (soc_v < 0)
            soc_v = 0;
        if (soc_v > 127)
            soc_v = 127;

        roll = $urandom_range(0, 99);
        if (roll < 20)
            temp_v = int'($urandom_range(0, 255)) - 128;
        else
        begin
            case ($urandom_range(0, 2))
                0: temp_v = gear1_exit;
                1: temp_v = gear_mid;
                default: temp_v = gear2_enter;
            endcase
            temp_v = temp_v + int'($urandom_range(0, 6)) - 3;
        end
        if (temp_v < -128)
            temp_v = -128;
        if (temp_v > 127)
            temp_v = 127;

        roll = $urandom_range(0, 99);
        if (roll < 5)
            bms_v = 0;
        else if (roll < 20)
            bms_v = 65535;
        else if (roll < 50)
            bms_v = $urandom_range(1, 2000);
        else
            bms_v = $urandom_range(0, 65535);

        tick = charge_tick(soc_v, bms_v, temp_v);
        tick.system_charge_permit = ($urandom_range(0, 99) < 90);
        tick.force_close          = ($urandom_range(0, 99) < 8);
        tick.mppt_charge_permit   = ($urandom_range(0, 99) < 88);
        tick.mppt_running         = ($urandom_range(0, 99) < 88);
        tick.dcac_charge_permit   = ($urandom_range(0, 99) < 88);
        tick.dcac_running         = ($urandom_range(0, 99) < 88);
        if ($urandom_range(0, 99) < 8)
        begin
            tick.mppt_shut_down        = 1'b1;
            tick.dcac_charge_shut_down = 1'b1;
        end
        else
        begin
            tick.mppt_shut_down        = ($urandom_range(0, 99) < 12);
            tick.dcac_charge_shut_down = ($urandom_range(0, 99) < 12);
        end
        return tick;
    endfunction

    task automatic record_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic write_reg(logic [cplp_pkg::CFG_INDEX_W-1:0] idx,
                             logic [cplp_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            cplp_pkg::REG_MPPT_INPUT_RATING:  mppt_rating = data;
            cplp_pkg::REG_DCAC_INPUT_RATING:  dcac_rating = data;
            cplp_pkg::REG_SOC_FULL_LEVEL:     full_level = data[6:0];
            cplp_pkg::REG_SOC_RECHARGE_LEVEL: recharge_level = data[6:0];
            cplp_pkg::REG_TEMP_GEAR1_EXIT:    gear1_exit = int'($signed(data[7:0]));
            cplp_pkg::REG_TEMP_GEAR_MID:      gear_mid = int'($signed(data[7:0]));
            cplp_pkg::REG_TEMP_GEAR2_ENTER:   gear2_enter = int'($signed(data[7:0]));
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Upper bits of the narrow registers carry random junk that the block must drop.
    task automatic set_policy(int mppt, int dcac, int full, int rech, int g1, int mid, int g2);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(cplp_pkg::REG_MPPT_INPUT_RATING, mppt[15:0]);
        write_reg(cplp_pkg::REG_DCAC_INPUT_RATING, dcac[15:0]);
        write_reg(cplp_pkg::REG_SOC_FULL_LEVEL, {junk[15:7], full[6:0]});
        junk = 16'($urandom);
        write_reg(cplp_pkg::REG_SOC_RECHARGE_LEVEL, {junk[15:7], rech[6:0]});
        junk = 16'($urandom);
        write_reg(cplp_pkg::REG_TEMP_GEAR1_EXIT, {junk[15:8], g1[7:0]});
        junk = 16'($urandom);
        write_reg(cplp_pkg::REG_TEMP_GEAR_MID, {junk[15:8], mid[7:0]});
        junk = 16'($urandom);
        write_reg(cplp_pkg::REG_TEMP_GEAR2_ENTER, {junk[15:8], g2[7:0]});
    endtask

    task automatic wait_quiet();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (ticks_to_send.size() != 0 || item_valid || setpoints_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_tick(cplp_pkg::item_t tick);
        ticks_to_send.push_back(tick);
    endtask

    // Item driver: a beat is held until taken, then the next one follows after a random gap.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            next_valid = item_valid;
            next_tick  = item;
            if (item_valid && tick_taken)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (ticks_to_send.size() > 0)
                begin
                    next_tick  = ticks_to_send.pop_front();
                    next_valid = 1'b1;
                    send_gap   = pick_gap(send_mode);
                end
            end
            item_valid <= next_valid;
            item       <= next_tick;
        end
    end

    // Result receiver: random stalls plus long hold-offs on request.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                stall_len = pick_gap(recv_mode);
                if (stall_len > 0)
                    stall_left = stall_len - 1;
                result_stall <= (stall_len > 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cplp_pkg::result_t want;
        if (rst_n)
        begin
            tick_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall)
                setpoints_due.push_back(predict_setpoints(item));
            if (result_valid && !result_stall)
            begin
                if (setpoints_due.size() == 0)
                    record_error($sformatf("result beat with nothing expected: mppt %0d dcac %0d",
                        result.mppt_power_setpoint, result.dcac_power_setpoint));
                else
                begin
                    want = setpoints_due.pop_front();
                    if (result.mppt_power_setpoint !== want.mppt_power_setpoint)
                        record_error($sformatf("mppt_power_setpoint expected %0d, got %0d",
                            want.mppt_power_setpoint, result.mppt_power_setpoint));
                    if (result.dcac_power_setpoint !== want.dcac_power_setpoint)
                        record_error($sformatf("dcac_power_setpoint expected %0d, got %0d",
                            want.dcac_power_setpoint, result.dcac_power_setpoint));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("charge_power_limit_policy test failed");
            $finish;
        end
    end

    initial
    begin
        cplp_pkg::item_t tick;
        int              g1;
        int              mid;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed ticks: base setpoint is 5000 with these ratings.
        set_policy(50000, 30000, 100, 90, 60, 65, 70);
        @(posedge clk);
        #1;
        push_tick(charge_tick(50, 65535, 25));
        push_tick(charge_tick(50, 1, 25));
        push_tick(charge_tick(50, 0, 25));
        tick = charge_tick(50, 65535, 25);
        tick.system_charge_permit = 1'b0;
        push_tick(tick);
        tick = charge_tick(50, 65535, 25);
        tick.force_close = 1'b1;
        push_tick(tick);
        tick = charge_tick(50, 65535, 25);
        tick.mppt_running = 1'b0;
        tick.dcac_charge_permit = 1'b0;
        push_tick(tick);
        push_tick(charge_tick(50, 65535, 66));
        push_tick(charge_tick(50, 65535, 66));
        push_tick(charge_tick(50, 65535, 71));
        push_tick(charge_tick(50, 65535, 68));
        push_tick(charge_tick(50, 65535, 65));
        push_tick(charge_tick(50, 65535, 60));
        push_tick(charge_tick(50, 65535, 127));
        push_tick(charge_tick(50, 65535, -128));
        push_tick(charge_tick(50, 65535, -128));
        push_tick(charge_tick(100, 65535, 25));
        push_tick(charge_tick(95, 65535, 25));
        push_tick(charge_tick(90, 65535, 25));
        push_tick(charge_tick(100, 65535, 25));
        tick = charge_tick(100, 65535, 25);
        tick.mppt_shut_down = 1'b1;
        tick.dcac_charge_shut_down = 1'b1;
        push_tick(tick);
        push_tick(charge_tick(127, 65535, 25));
        push_tick(charge_tick(0, 65535, 25));
        tick = charge_tick(100, 65535, 25);
        tick.mppt_shut_down = 1'b1;
        push_tick(tick);
        push_tick(charge_tick(0, 65535, 25));
        tick = charge_tick(50, 65535, 127);
        tick.mppt_charge_permit = 1'b0;
        push_tick(tick);
        wait_quiet();

        for (int phase = 1; phase <= 6; phase++)
        begin
            case (phase)
                1:
                begin
                    set_policy(65535, 65535, 100, 90, 60, 65, 70);
                    send_mode = IDLE_NONE;
                    recv_mode = IDLE_NONE;
                end
                2:
                begin
                    set_policy(0, 0, 0, 0, -128, -128, -128);
                    write_reg(REG_UNUSED, 16'($urandom));
                    send_mode = IDLE_LIGHT;
                    recv_mode = IDLE_LIGHT;
                end
                3:
                begin
                    set_policy(9, 1, 127, 127, 127, 127, 127);
                    send_mode = IDLE_HEAVY;
                    recv_mode = IDLE_NONE;
                end
                4:
                begin
                    set_policy($urandom_range(0, 65535), $urandom_range(0, 65535), 50, 60,
                        20, 10, 30);
                    send_mode = IDLE_NONE;
                    recv_mode = IDLE_HEAVY;
                end
                5:
                begin
                    set_policy($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 127), $urandom_range(0, 127),
                        int'($urandom_range(0, 255)) - 128, int'($urandom_range(0, 255)) - 128,
                        int'($urandom_range(0, 255)) - 128);
                    send_mode = IDLE_HEAVY;
                    recv_mode = IDLE_HEAVY;
                end
                default:
                begin
                    g1 = int'($urandom_range(0, 100)) - 40;
                    mid = g1 + int'($urandom_range(0, 10));
                    set_policy($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(80, 100), $urandom_range(60, 95),
                        g1, mid, mid + int'($urandom_range(0, 10)));
                    send_mode = IDLE_LIGHT;
                    recv_mode = IDLE_HEAVY;
                end
            endcase
            @(posedge clk);
            #1;
            for (int n = 0; n < RANDOM_TICKS; n++)
                push_tick(random_tick());
            if (phase == 1 || phase == 4)
                holds_asked++;
            wait_quiet();
        end

        if (error_count == 0 && setpoints_due.size() == 0)
            $display("charge_power_limit_policy test passed");
        else
            $display("charge_power_limit_policy test failed");
        $finish;
    end

endmodule
